// File: sv/lsop_pkg.sv
// shared types, constants and the arctangent table of the scan-to-points block
package lsop_pkg;

	localparam int CORDIC_STAGES = 16;
	localparam int ATAN_COUNT    = 24;

	localparam int RW  = 16;  // range width
	localparam int AW  = 16;  // binary angle width
	localparam int PW  = 24;  // point / pose width
	localparam int GW  = 30;  // gain constant width
	localparam int MW  = RW + GW;  // gain product width
	localparam int XW  = 36;  // cordic x/y width, 16 fraction bits
	localparam int ZW  = 34;  // residual angle width, 2^32 per circle
	localparam int SW  = 5;   // stage index width
	localparam int FW  = 16;  // fraction bits of x/y
	localparam int RDW = XW - FW + 1;  // rounded and negated width
	localparam int SUMW = PW + 2;

	localparam logic [GW-1:0] GAIN_Q30 = GW'(652032874);

	localparam int CFG_IW = 3;
	localparam int CFG_DW = 24;

	typedef enum logic [CFG_IW-1:0] {
		REG_RANGE_FLOOR    = 3'd0,
		REG_RANGE_CEILING  = 3'd1,
		REG_ANGLE_START    = 3'd2,
		REG_ANGLE_STEP     = 3'd3,
		REG_POSE_X         = 3'd4,
		REG_POSE_Y         = 3'd5,
		REG_OBSTACLE_LIMIT = 3'd6
	} cfg_reg_t;

	localparam logic [RW-1:0] OBSTACLE_LIMIT_RST = RW'(6144);

	typedef struct packed {
		logic [RW-1:0]        range_floor;
		logic [RW-1:0]        range_ceiling;
		logic [AW-1:0]        angle_start;
		logic [AW-1:0]        angle_step;
		logic signed [PW-1:0] pose_x;
		logic signed [PW-1:0] pose_y;
		logic [RW-1:0]        obstacle_limit;
	} cfg_t;

	// one cordic cell's hand-off to its neighbor
	typedef struct packed {
		logic                 valid;
		logic                 hit;
		logic                 flip;
		logic                 last;
		logic signed [XW-1:0] x;
		logic signed [XW-1:0] y;
		logic signed [ZW-1:0] z;
	} cell_t;

	// round(atan(2^-i) * 2^32 / (2 pi))
	function automatic logic [GW-1:0] atan_lut(input logic [SW-1:0] idx);
		logic [GW-1:0] v;
		case (idx)
			5'd0:  v = GW'(536870912);
			5'd1:  v = GW'(316933406);
			5'd2:  v = GW'(167458907);
			5'd3:  v = GW'(85004756);
			5'd4:  v = GW'(42667331);
			5'd5:  v = GW'(21354465);
			5'd6:  v = GW'(10679838);
			5'd7:  v = GW'(5340245);
			5'd8:  v = GW'(2670163);
			5'd9:  v = GW'(1335087);
			5'd10: v = GW'(667544);
			5'd11: v = GW'(333772);
			5'd12: v = GW'(166886);
			5'd13: v = GW'(83443);
			5'd14: v = GW'(41722);
			5'd15: v = GW'(20861);
			5'd16: v = GW'(10430);
			5'd17: v = GW'(5215);
			5'd18: v = GW'(2608);
			5'd19: v = GW'(1304);
			5'd20: v = GW'(652);
			5'd21: v = GW'(326);
			5'd22: v = GW'(163);
			5'd23: v = GW'(81);
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

// File: sv/lsop_sample_if.sv
// range sample channel
interface lsop_sample_if;
	logic                    valid;
	logic                    ready;
	logic [lsop_pkg::RW-1:0] range_sample;
	logic                    last_sample;

	modport source (output valid, range_sample, last_sample, input ready);
	modport sink (input valid, range_sample, last_sample, output ready);
endinterface

// File: sv/lsop_point_if.sv
// obstacle point channel
interface lsop_point_if;
	logic                           valid;
	logic                           ready;
	logic                           is_obstacle;
	logic signed [lsop_pkg::PW-1:0] point_x;
	logic signed [lsop_pkg::PW-1:0] point_y;
	logic                           scan_end;

	modport source (output valid, is_obstacle, point_x, point_y, scan_end, input ready);
	modport sink (input valid, is_obstacle, point_x, point_y, scan_end, output ready);
endinterface

// File: sv/lsop_cfg_if.sv
// register write channel
interface lsop_cfg_if;
	logic                        valid;
	logic                        ready;
	logic [lsop_pkg::CFG_IW-1:0] index;
	logic [lsop_pkg::CFG_DW-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// File: sv/lsop_front.sv
// beam angle tracking, range gating, angle folding and gain multiply
module lsop_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            en,
	input  logic                            valid,
	input  logic [lsop_pkg::RW-1:0]         range_sample,
	input  logic                            last_sample,
	input  lsop_pkg::cfg_t                  cfg,
	output lsop_pkg::cell_t                 cell_out
);

	logic [lsop_pkg::AW-1:0] beam_angle_q;
	logic                    scan_first_q;
	logic [lsop_pkg::AW-1:0] angle;
	logic [lsop_pkg::AW-1:0] folded;
	logic                    flip;
	logic                    hit;

	logic                    valid_s1;
	logic                    hit_s1;
	logic                    flip_s1;
	logic                    last_s1;
	logic [lsop_pkg::MW-1:0] prod_s1;
	logic signed [lsop_pkg::ZW-1:0] z_s1;

	assign angle  = scan_first_q ? cfg.angle_start : beam_angle_q;
	// quadrants two and three rotate by a half circle, result negated later
	assign flip   = angle[lsop_pkg::AW-1] ^ angle[lsop_pkg::AW-2];
	assign folded = {angle[lsop_pkg::AW-1] ^ flip, angle[lsop_pkg::AW-2:0]};
	assign hit    = (range_sample >= cfg.range_floor) && (range_sample <= cfg.range_ceiling)
		&& (range_sample < cfg.obstacle_limit);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beam_angle_q <= '0;
			scan_first_q <= 1'b1;
			valid_s1     <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid;
			if (valid) begin
				beam_angle_q <= angle + cfg.angle_step;
				scan_first_q <= last_sample;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hit_s1  <= hit;
			flip_s1 <= flip;
			last_s1 <= last_sample;
			prod_s1 <= lsop_pkg::MW'(range_sample) * lsop_pkg::MW'(lsop_pkg::GAIN_Q30);
			z_s1    <= lsop_pkg::ZW'($signed({folded, 16'h0000}));
		end
	end

	always_comb begin
		cell_out.valid = valid_s1;
		cell_out.hit   = hit_s1;
		cell_out.flip  = flip_s1;
		cell_out.last  = last_s1;
		cell_out.x     = $signed(lsop_pkg::XW'(prod_s1[lsop_pkg::MW-1:14]));
		cell_out.y     = '0;
		cell_out.z     = z_s1;
	end

endmodule

// File: sv/lsop_cell.sv
// one cordic rotation step, registered toward the next cell
module lsop_cell (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic [lsop_pkg::SW-1:0] stage,
	input  lsop_pkg::cell_t         cell_in,
	output lsop_pkg::cell_t         cell_out
);

	logic signed [lsop_pkg::XW-1:0] xs;
	logic signed [lsop_pkg::XW-1:0] ys;
	logic signed [lsop_pkg::ZW-1:0] at;
	logic                           up;

	logic                           valid_q;
	logic                           hit_q;
	logic                           flip_q;
	logic                           last_q;
	logic signed [lsop_pkg::XW-1:0] x_q;
	logic signed [lsop_pkg::XW-1:0] y_q;
	logic signed [lsop_pkg::ZW-1:0] z_q;

	assign xs = cell_in.x >>> stage;
	assign ys = cell_in.y >>> stage;
	assign at = $signed(lsop_pkg::ZW'(lsop_pkg::atan_lut(stage)));
	assign up = !cell_in.z[lsop_pkg::ZW-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= cell_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hit_q  <= cell_in.hit;
			flip_q <= cell_in.flip;
			last_q <= cell_in.last;
			x_q    <= up ? cell_in.x - ys : cell_in.x + ys;
			y_q    <= up ? cell_in.y + xs : cell_in.y - xs;
			z_q    <= up ? cell_in.z - at : cell_in.z + at;
		end
	end

	always_comb begin
		cell_out.valid = valid_q;
		cell_out.hit   = hit_q;
		cell_out.flip  = flip_q;
		cell_out.last  = last_q;
		cell_out.x     = x_q;
		cell_out.y     = y_q;
		cell_out.z     = z_q;
	end

endmodule

// File: sv/lsop_back.sv
// rounding, unfolding, pose offset, saturation and output register
module lsop_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           en,
	input  lsop_pkg::cell_t                cell_in,
	input  logic signed [lsop_pkg::PW-1:0] pose_x,
	input  logic signed [lsop_pkg::PW-1:0] pose_y,
	output logic                           valid,
	output logic                           is_obstacle,
	output logic signed [lsop_pkg::PW-1:0] point_x,
	output logic signed [lsop_pkg::PW-1:0] point_y,
	output logic                           scan_end
);

	localparam logic signed [lsop_pkg::XW-1:0] HALF = lsop_pkg::XW'(32768);
	localparam logic signed [lsop_pkg::SUMW-1:0] SAT_HI = lsop_pkg::SUMW'(8388607);
	localparam logic signed [lsop_pkg::SUMW-1:0] SAT_LO = -lsop_pkg::SUMW'(8388608);

	logic signed [lsop_pkg::XW-1:0]   xh;
	logic signed [lsop_pkg::XW-1:0]   yh;
	logic signed [lsop_pkg::RDW-1:0]  xr;
	logic signed [lsop_pkg::RDW-1:0]  yr;

	logic                             valid_s2;
	logic                             hit_s2;
	logic                             last_s2;
	logic signed [lsop_pkg::RDW-1:0]  x_s2;
	logic signed [lsop_pkg::RDW-1:0]  y_s2;

	logic signed [lsop_pkg::SUMW-1:0] sx;
	logic signed [lsop_pkg::SUMW-1:0] sy;

	logic                             valid_q;
	logic                             hit_q;
	logic                             last_q;
	logic signed [lsop_pkg::PW-1:0]   x_q;
	logic signed [lsop_pkg::PW-1:0]   y_q;

	function automatic logic signed [lsop_pkg::PW-1:0] sat(
		input logic signed [lsop_pkg::SUMW-1:0] v);
		logic signed [lsop_pkg::PW-1:0] r;
		if (v > SAT_HI) begin
			r = lsop_pkg::PW'(SAT_HI);
		end else if (v < SAT_LO) begin
			r = lsop_pkg::PW'(SAT_LO);
		end else begin
			r = lsop_pkg::PW'(v);
		end
		return r;
	endfunction

	assign xh = cell_in.x + HALF;
	assign yh = cell_in.y + HALF;
	assign xr = lsop_pkg::RDW'($signed(xh[lsop_pkg::XW-1:lsop_pkg::FW]));
	assign yr = lsop_pkg::RDW'($signed(yh[lsop_pkg::XW-1:lsop_pkg::FW]));

	assign sx = lsop_pkg::SUMW'(x_s2) + lsop_pkg::SUMW'(pose_x);
	assign sy = lsop_pkg::SUMW'(y_s2) + lsop_pkg::SUMW'(pose_y);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_q  <= 1'b0;
		end else if (en) begin
			valid_s2 <= cell_in.valid;
			valid_q  <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hit_s2  <= cell_in.hit;
			last_s2 <= cell_in.last;
			x_s2    <= cell_in.flip ? -xr : xr;
			y_s2    <= cell_in.flip ? -yr : yr;
			hit_q   <= hit_s2;
			last_q  <= last_s2;
			// dropped samples report the origin
			x_q     <= hit_s2 ? sat(sx) : '0;
			y_q     <= hit_s2 ? sat(sy) : '0;
		end
	end

	assign valid       = valid_q;
	assign is_obstacle = hit_q;
	assign point_x     = x_q;
	assign point_y     = y_q;
	assign scan_end    = last_q;

endmodule

// File: sv/laser_scan_to_obstacle_points.sv
// top level: laser range samples in, world-frame obstacle points out
//
// One range sample is taken per clock unless the output stalls, and one point comes out
// per sample, in order. The front stage picks the beam angle, gates the range and
// multiplies it by the cordic gain; a row of CORDIC_STAGES identical cells then rotates
// the vector one step each, every cell passing its x, y and residual angle to the next
// whenever the row advances; the back end rounds, undoes the half-circle fold, adds the
// pose and saturates to 24 bits. The whole row moves together: it advances whenever the
// output register is empty or its beat is taken, so samples keep flowing back to back
// until the point sink holds off, and the sample channel stalls only while an unread
// point waits at the output. Registers are written through the config channel, always
// ready, and should only change while no sample is in flight.
module laser_scan_to_obstacle_points (
	input  logic         clk,
	input  logic         arst_n,
	lsop_sample_if.sink  samples,
	lsop_point_if.source points,
	lsop_cfg_if.sink     cfg
);

	lsop_pkg::cfg_t  cfg_q;
	logic            en;

	// hand-off between neighbors: entry 0 from the front, entry N from the last cell
	lsop_pkg::cell_t chain [lsop_pkg::CORDIC_STAGES+1];

	// the whole pipe advances while the output register can take a beat
	assign en            = !points.valid || points.ready;
	assign samples.ready = en;
	assign cfg.ready     = 1'b1;

	// register file, writes to unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.range_floor    <= '0;
			cfg_q.range_ceiling  <= '1;
			cfg_q.angle_start    <= '0;
			cfg_q.angle_step     <= '0;
			cfg_q.pose_x         <= '0;
			cfg_q.pose_y         <= '0;
			cfg_q.obstacle_limit <= lsop_pkg::OBSTACLE_LIMIT_RST;
		end else if (cfg.valid && cfg.ready) begin
			case (lsop_pkg::cfg_reg_t'(cfg.index))
				lsop_pkg::REG_RANGE_FLOOR: begin
					cfg_q.range_floor <= cfg.data[lsop_pkg::RW-1:0];
				end
				lsop_pkg::REG_RANGE_CEILING: begin
					cfg_q.range_ceiling <= cfg.data[lsop_pkg::RW-1:0];
				end
				lsop_pkg::REG_ANGLE_START: begin
					cfg_q.angle_start <= cfg.data[lsop_pkg::AW-1:0];
				end
				lsop_pkg::REG_ANGLE_STEP: begin
					cfg_q.angle_step <= cfg.data[lsop_pkg::AW-1:0];
				end
				lsop_pkg::REG_POSE_X: begin
					cfg_q.pose_x <= $signed(cfg.data[lsop_pkg::PW-1:0]);
				end
				lsop_pkg::REG_POSE_Y: begin
					cfg_q.pose_y <= $signed(cfg.data[lsop_pkg::PW-1:0]);
				end
				lsop_pkg::REG_OBSTACLE_LIMIT: begin
					cfg_q.obstacle_limit <= cfg.data[lsop_pkg::RW-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// angle pick, gating, quadrant fold and gain multiply
	lsop_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (en),
		.valid        (samples.valid),
		.range_sample (samples.range_sample),
		.last_sample  (samples.last_sample),
		.cfg          (cfg_q),
		.cell_out     (chain[0])
	);

	// row of rotation cells, cell g shifts by g and uses atan(2^-g)
	for (genvar g = 0; g < lsop_pkg::CORDIC_STAGES; g++) begin : g_cell
		lsop_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.stage    (lsop_pkg::SW'(g)),
			.cell_in  (chain[g]),
			.cell_out (chain[g+1])
		);
	end

	// rounding, pose offset, saturation and the output register
	lsop_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.cell_in     (chain[lsop_pkg::CORDIC_STAGES]),
		.pose_x      (cfg_q.pose_x),
		.pose_y      (cfg_q.pose_y),
		.valid       (points.valid),
		.is_obstacle (points.is_obstacle),
		.point_x     (points.point_x),
		.point_y     (points.point_y),
		.scan_end    (points.scan_end)
	);

endmodule

// File: sv/lsop_checker.sv
// port-level checks of the scan-to-points block and their bind
module lsop_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_ready,
	input logic                           out_valid,
	input logic                           out_ready,
	input logic                           is_obstacle,
	input logic signed [lsop_pkg::PW-1:0] point_x,
	input logic signed [lsop_pkg::PW-1:0] point_y,
	input logic                           scan_end
);

	// a held point beat keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(point_x) && $stable(point_y)
			&& $stable(is_obstacle) && $stable(scan_end))
		else $error("point beat changed while stalled");

	// dropped samples report the origin
	a_drop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !is_obstacle |-> point_x == '0 && point_y == '0)
		else $error("dropped sample with nonzero point");

	// an empty output never blocks samples
	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("sample channel stalled with empty output");

	// samples stall only behind a held point
	a_ready_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("sample channel stalled without a held point");

endmodule

bind laser_scan_to_obstacle_points lsop_checker u_lsop_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_ready    (samples.ready),
	.out_valid   (points.valid),
	.out_ready   (points.ready),
	.is_obstacle (points.is_obstacle),
	.point_x     (points.point_x),
	.point_y     (points.point_y),
	.scan_end    (points.scan_end)
);
